@@ design/ipod_pkg.sv @@
// Shared types, constants and helpers for the proximity obstacle direction block.
// No dependencies; every other file refers to it by scoped names.
package ipod_pkg;

    localparam int CHANNELS     = 8;
    localparam int SAMPLE_BITS  = 12;
    localparam int CFG_BITS     = 12;
    localparam int CFG_IDX_BITS = 3;
    localparam int ANGLE_BITS   = 9;
    localparam int SUM_BITS     = 11;
    localparam int MAG_BITS     = 10;
    localparam int COUNT_BITS   = 4;
    localparam int REM_BITS     = 5;
    localparam int DIV_STEPS    = MAG_BITS;
    localparam int STEP_BITS    = $clog2(DIV_STEPS);
    localparam int QUEUE_DEPTH  = 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_IGNORE      = 3'd0,
        REG_TRIG_HIGH   = 3'd1,
        REG_TRIG_LOW    = 3'd2,
        REG_CLOSE       = 3'd3,
        REG_VALID_LIMIT = 3'd4,
        REG_SIDE_CORR   = 3'd5
    } cfg_idx_t;

    typedef logic [1:0] grade_t;
    localparam grade_t GRADE_NONE     = 2'd0;
    localparam grade_t GRADE_DETECTED = 2'd1;
    localparam grade_t GRADE_DANGER   = 2'd2;

    typedef grade_t [CHANNELS-1:0] grade_vec_t;

    typedef struct packed {
        logic                       ignore;
        logic [CFG_BITS-1:0]        trig_high;
        logic [CFG_BITS-1:0]        trig_low;
        logic [CFG_BITS-1:0]        close_level;
        logic [CFG_BITS-1:0]        valid_limit;
        logic signed [CFG_BITS-1:0] side_corr;
    } cfg_t;

    localparam logic [CFG_BITS-1:0] RST_TRIG_HIGH   = 12'd200;
    localparam logic [CFG_BITS-1:0] RST_TRIG_LOW    = 12'd100;
    localparam logic [CFG_BITS-1:0] RST_CLOSE       = 12'd700;
    localparam logic [CFG_BITS-1:0] RST_VALID_LIMIT = 12'd3000;

    localparam logic signed [SUM_BITS-1:0] REAR_ANGLE = 11'sd180;

    function automatic logic signed [ANGLE_BITS-1:0] mount_angle(input logic [2:0] ch);
        logic signed [ANGLE_BITS-1:0] a;
        case (ch)
            3'd0:    a = -9'sd17;
            3'd1:    a = -9'sd49;
            3'd2:    a = -9'sd90;
            3'd3:    a = -9'sd120;
            3'd4:    a = 9'sd120;
            3'd5:    a = 9'sd90;
            3'd6:    a = 9'sd49;
            3'd7:    a = 9'sd17;
            default: a = 9'sd0;
        endcase
        return a;
    endfunction

    function automatic logic has_corr(input logic [2:0] ch);
        return (ch == 3'd0) || (ch == 3'd3) || (ch == 3'd4) || (ch == 3'd7);
    endfunction

endpackage

@@ design/ipod_if.sv @@
// Handshake channels: the sample frame in and the obstacle result out.
// Depends on ipod_pkg for default widths.
interface ipod_frame_if #(parameter int SAMPLE_BITS = ipod_pkg::SAMPLE_BITS);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_0;
    logic [SAMPLE_BITS-1:0] sample_1;
    logic [SAMPLE_BITS-1:0] sample_2;
    logic [SAMPLE_BITS-1:0] sample_3;
    logic [SAMPLE_BITS-1:0] sample_4;
    logic [SAMPLE_BITS-1:0] sample_5;
    logic [SAMPLE_BITS-1:0] sample_6;
    logic [SAMPLE_BITS-1:0] sample_7;

    modport source (output valid, sample_0, sample_1, sample_2, sample_3,
                    sample_4, sample_5, sample_6, sample_7, input ready);
    modport sink   (input valid, sample_0, sample_1, sample_2, sample_3,
                    sample_4, sample_5, sample_6, sample_7, output ready);
endinterface

interface ipod_result_if;
    logic                                    valid;
    logic                                    ready;
    logic [1:0]                              obstacle_level;
    logic signed [ipod_pkg::ANGLE_BITS-1:0]  direction_deg;
    logic                                    ahead_clear;
    logic                                    stop_drive;
    logic [ipod_pkg::COUNT_BITS-1:0]         triggered_count;

    modport source (output valid, obstacle_level, direction_deg, ahead_clear,
                    stop_drive, triggered_count, input ready);
    modport sink   (input valid, obstacle_level, direction_deg, ahead_clear,
                    stop_drive, triggered_count, output ready);
endinterface

@@ design/ipod_front.sv @@
// Front end: accepts a sample frame, filters each channel and grades it with hysteresis.
// Depends on ipod_pkg and ipod_frame_if; pushes the graded frame into ipod_queue.
module ipod_front #(
    parameter int SAMPLE_BITS = ipod_pkg::SAMPLE_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    ipod_frame_if.sink           frame,
    input  ipod_pkg::cfg_t       cfg,
    input  logic                 full,
    output logic                 push,
    output ipod_pkg::grade_vec_t push_grades
);

    localparam int LW = (SAMPLE_BITS > ipod_pkg::CFG_BITS) ? SAMPLE_BITS : ipod_pkg::CFG_BITS;
    localparam int CW = LW + 2;

    logic [SAMPLE_BITS-1:0]  smp        [ipod_pkg::CHANNELS];
    logic [SAMPLE_BITS-1:0]  filt_reg   [ipod_pkg::CHANNELS];
    logic [SAMPLE_BITS-1:0]  filt_next  [ipod_pkg::CHANNELS];
    logic [SAMPLE_BITS-1:0]  avg        [ipod_pkg::CHANNELS];
    logic                    take       [ipod_pkg::CHANNELS];
    logic signed [CW-1:0]    corr       [ipod_pkg::CHANNELS];
    logic signed [CW-1:0]    lvl        [ipod_pkg::CHANNELS];
    logic signed [CW-1:0]    thr_close  [ipod_pkg::CHANNELS];
    logic signed [CW-1:0]    thr_high   [ipod_pkg::CHANNELS];
    logic signed [CW-1:0]    thr_low    [ipod_pkg::CHANNELS];
    ipod_pkg::grade_vec_t    grade_reg;
    ipod_pkg::grade_vec_t    grade_next;
    logic signed [CW-1:0]    corr_ext;
    logic                    accept;

    assign smp[0] = frame.sample_0;
    assign smp[1] = frame.sample_1;
    assign smp[2] = frame.sample_2;
    assign smp[3] = frame.sample_3;
    assign smp[4] = frame.sample_4;
    assign smp[5] = frame.sample_5;
    assign smp[6] = frame.sample_6;
    assign smp[7] = frame.sample_7;

    assign frame.ready = !full;
    assign accept      = frame.valid && !full;
    assign push        = accept;
    assign push_grades = grade_next;
    assign corr_ext    = {{(CW-ipod_pkg::CFG_BITS){cfg.side_corr[ipod_pkg::CFG_BITS-1]}},
                          cfg.side_corr};

    always_comb
    begin
        for (int ch = 0; ch < ipod_pkg::CHANNELS; ch++)
        begin
            corr[ch]      = ipod_pkg::has_corr(3'(ch)) ? corr_ext : '0;
            take[ch]      = LW'(smp[ch]) < LW'(cfg.valid_limit);
            avg[ch]       = SAMPLE_BITS'(({1'b0, smp[ch]} + {1'b0, filt_reg[ch]}) >> 1);
            lvl[ch]       = $signed({2'b00, LW'(avg[ch])});
            thr_close[ch] = $signed({2'b00, LW'(cfg.close_level)}) + corr[ch];
            thr_high[ch]  = $signed({2'b00, LW'(cfg.trig_high)}) + corr[ch];
            thr_low[ch]   = $signed({2'b00, LW'(cfg.trig_low)}) + corr[ch];
            filt_next[ch] = filt_reg[ch];
            grade_next[ch] = grade_reg[ch];
            if (take[ch])
            begin
                filt_next[ch] = avg[ch];
                if (lvl[ch] > thr_close[ch])
                    grade_next[ch] = ipod_pkg::GRADE_DANGER;
                else if (lvl[ch] > thr_high[ch])
                    grade_next[ch] = ipod_pkg::GRADE_DETECTED;
                else if (lvl[ch] < thr_low[ch])
                    grade_next[ch] = ipod_pkg::GRADE_NONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int ch = 0; ch < ipod_pkg::CHANNELS; ch++)
            begin
                filt_reg[ch] <= '0;
            end
            grade_reg <= '0;
        end
        else if (accept)
        begin
            for (int ch = 0; ch < ipod_pkg::CHANNELS; ch++)
            begin
                filt_reg[ch] <= filt_next[ch];
            end
            grade_reg <= grade_next;
        end
    end

endmodule

@@ design/ipod_queue.sv @@
// Short queue of graded frames between the front end and the back end.
// Depends on ipod_pkg for the entry type and depth.
module ipod_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  ipod_pkg::grade_vec_t push_grades,
    input  logic                 pop,
    output logic                 full,
    output logic                 head_valid,
    output ipod_pkg::grade_vec_t head_grades
);

    localparam int PTR_BITS = (ipod_pkg::QUEUE_DEPTH > 1) ? $clog2(ipod_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(ipod_pkg::QUEUE_DEPTH + 1);

    ipod_pkg::grade_vec_t  entry_reg [ipod_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [CNT_BITS-1:0]   count_reg;
    logic                  do_push;
    logic                  do_pop;

    assign full        = count_reg == CNT_BITS'(ipod_pkg::QUEUE_DEPTH);
    assign head_valid  = count_reg != '0;
    assign head_grades = entry_reg[rd_ptr_reg];
    assign do_push     = push && !full;
    assign do_pop      = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_grades;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(ipod_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(ipod_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

@@ design/ipod_back.sv @@
// Back end: sums triggered channels, ratchets the level, divides for the mean angle.
// Depends on ipod_pkg and ipod_result_if; pops graded frames from ipod_queue.
module ipod_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  ipod_pkg::grade_vec_t head_grades,
    input  logic                 ignore,
    output logic                 pop,
    ipod_result_if.source        result
);

    typedef enum logic [1:0] {ST_IDLE, ST_DIVIDE, ST_FINISH} state_t;

    state_t                                   state_reg;
    logic [1:0]                               held_reg;
    logic [1:0]                               held_next;
    logic                                     neg_reg;
    logic [ipod_pkg::MAG_BITS-1:0]            dq_reg;
    logic [ipod_pkg::REM_BITS-1:0]            rem_reg;
    logic [ipod_pkg::COUNT_BITS-1:0]          div_reg;
    logic [ipod_pkg::STEP_BITS-1:0]           step_reg;
    logic [ipod_pkg::COUNT_BITS-1:0]          cnt_reg;
    logic                                     ahead_reg;
    logic                                     out_valid_reg;
    logic [1:0]                               out_level_reg;
    logic signed [ipod_pkg::ANGLE_BITS-1:0]   out_dir_reg;
    logic                                     out_ahead_reg;
    logic                                     out_stop_reg;
    logic [ipod_pkg::COUNT_BITS-1:0]          out_cnt_reg;

    logic [ipod_pkg::CHANNELS-1:0]            trig;
    logic [ipod_pkg::COUNT_BITS-1:0]          count;
    logic signed [ipod_pkg::SUM_BITS-1:0]     sum;
    logic signed [ipod_pkg::SUM_BITS-1:0]     sum_sel;
    logic signed [ipod_pkg::SUM_BITS-1:0]     sum_abs;
    logic signed [ipod_pkg::ANGLE_BITS-1:0]   ang;
    ipod_pkg::grade_t                         max_grade;
    logic [ipod_pkg::REM_BITS-1:0]            rem_shift;
    logic                                     q_bit;
    logic signed [ipod_pkg::SUM_BITS-1:0]     dir_full;
    logic                                     slot_free;

    assign pop       = (state_reg == ST_IDLE) && head_valid;
    assign slot_free = !out_valid_reg || result.ready;

    assign result.valid           = out_valid_reg;
    assign result.obstacle_level  = out_level_reg;
    assign result.direction_deg   = out_dir_reg;
    assign result.ahead_clear     = out_ahead_reg;
    assign result.stop_drive      = out_stop_reg;
    assign result.triggered_count = out_cnt_reg;

    always_comb
    begin
        count     = '0;
        sum       = '0;
        max_grade = ipod_pkg::GRADE_NONE;
        for (int ch = 0; ch < ipod_pkg::CHANNELS; ch++)
        begin
            ang      = ipod_pkg::mount_angle(3'(ch));
            trig[ch] = head_grades[ch] != ipod_pkg::GRADE_NONE;
            if (trig[ch])
            begin
                count = count + 1'b1;
                sum   = sum + {{(ipod_pkg::SUM_BITS-ipod_pkg::ANGLE_BITS){ang[ipod_pkg::ANGLE_BITS-1]}},
                               ang};
                if (head_grades[ch] > max_grade)
                    max_grade = head_grades[ch];
            end
        end
        sum_sel = sum;
        if (trig[3] && trig[4])
        begin
            sum_sel = ipod_pkg::REAR_ANGLE;
            count   = ipod_pkg::COUNT_BITS'(1);
        end
        sum_abs = sum_sel[ipod_pkg::SUM_BITS-1] ? -sum_sel : sum_sel;
        if (count == '0)
            held_next = ipod_pkg::GRADE_NONE;
        else if (max_grade > held_reg)
            held_next = max_grade;
        else
            held_next = held_reg;

        rem_shift = {rem_reg[ipod_pkg::REM_BITS-2:0], dq_reg[ipod_pkg::MAG_BITS-1]};
        q_bit     = rem_shift >= {1'b0, div_reg};

        dir_full = neg_reg ? -$signed({1'b0, dq_reg}) : $signed({1'b0, dq_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            held_reg      <= ipod_pkg::GRADE_NONE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            if (out_valid_reg && result.ready && (state_reg != ST_FINISH))
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (head_valid)
                    begin
                        held_reg  <= held_next;
                        neg_reg   <= sum_sel[ipod_pkg::SUM_BITS-1];
                        dq_reg    <= sum_abs[ipod_pkg::MAG_BITS-1:0];
                        rem_reg   <= '0;
                        div_reg   <= (count == '0) ? ipod_pkg::COUNT_BITS'(1) : count;
                        cnt_reg   <= count;
                        ahead_reg <= !(trig[0] || trig[1] || trig[6] || trig[7]);
                        step_reg  <= '0;
                        state_reg <= ST_DIVIDE;
                    end
                end
                ST_DIVIDE:
                begin
                    rem_reg  <= q_bit ? rem_shift - {1'b0, div_reg} : rem_shift;
                    dq_reg   <= {dq_reg[ipod_pkg::MAG_BITS-2:0], q_bit};
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == ipod_pkg::STEP_BITS'(ipod_pkg::DIV_STEPS - 1))
                        state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_level_reg <= held_reg;
                        out_dir_reg   <= dir_full[ipod_pkg::ANGLE_BITS-1:0];
                        out_ahead_reg <= ahead_reg;
                        out_stop_reg  <= (cnt_reg != '0) && !ignore;
                        out_cnt_reg   <= cnt_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ design/ir_proximity_obstacle_direction.sv @@
// A result is registered when the back end's serial divider is done and the output is free.
// The back end pops the next frame only once its ten-step divider and result write are done.
// The front end takes frames at once while the two-entry queue has room.
// Reset clears filtered levels, channel grades and the held level, and loads register defaults.
// Top level: configuration registers, front end, queue and back end.
module ir_proximity_obstacle_direction #(
    parameter int SAMPLE_BITS = ipod_pkg::SAMPLE_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    ipod_frame_if.sink                        frame,
    ipod_result_if.source                     result,
    input  logic                              cfg_we,
    input  logic [ipod_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [ipod_pkg::CFG_BITS-1:0]     cfg_data
);

    ipod_pkg::cfg_t       cfg_reg;
    logic                 push;
    ipod_pkg::grade_vec_t push_grades;
    logic                 full;
    logic                 pop;
    logic                 head_valid;
    ipod_pkg::grade_vec_t head_grades;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ignore      <= 1'b0;
            cfg_reg.trig_high   <= ipod_pkg::RST_TRIG_HIGH;
            cfg_reg.trig_low    <= ipod_pkg::RST_TRIG_LOW;
            cfg_reg.close_level <= ipod_pkg::RST_CLOSE;
            cfg_reg.valid_limit <= ipod_pkg::RST_VALID_LIMIT;
            cfg_reg.side_corr   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ipod_pkg::REG_IGNORE:      cfg_reg.ignore      <= cfg_data[0];
                ipod_pkg::REG_TRIG_HIGH:   cfg_reg.trig_high   <= cfg_data;
                ipod_pkg::REG_TRIG_LOW:    cfg_reg.trig_low    <= cfg_data;
                ipod_pkg::REG_CLOSE:       cfg_reg.close_level <= cfg_data;
                ipod_pkg::REG_VALID_LIMIT: cfg_reg.valid_limit <= cfg_data;
                ipod_pkg::REG_SIDE_CORR:   cfg_reg.side_corr   <= $signed(cfg_data);
                default:
                begin
                end
            endcase
        end
    end

    ipod_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame       (frame),
        .cfg         (cfg_reg),
        .full        (full),
        .push        (push),
        .push_grades (push_grades)
    );

    ipod_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_grades (push_grades),
        .pop         (pop),
        .full        (full),
        .head_valid  (head_valid),
        .head_grades (head_grades)
    );

    ipod_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_grades (head_grades),
        .ignore      (cfg_reg.ignore),
        .pop         (pop),
        .result      (result)
    );

`ifndef ASSERT_OFF
    a_none_means_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.triggered_count == 4'd0) |->
            (result.direction_deg == 9'sd0) && !result.stop_drive &&
            (result.obstacle_level == ipod_pkg::GRADE_NONE) && result.ahead_clear)
        else $error("empty frame result not neutral");

    a_level_needs_trigger: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.obstacle_level != ipod_pkg::GRADE_NONE) |->
            (result.triggered_count != 4'd0))
        else $error("obstacle level without a triggered channel");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.triggered_count <= 4'd8) &&
            (result.obstacle_level != 2'd3))
        else $error("result fields out of range");

    a_stop_follows_ignore: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && cfg_reg.ignore |-> !result.stop_drive)
        else $error("stop raised while ignoring obstacles");
`endif

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for ir_proximity_obstacle_direction: directed frames, register extremes
// and random frame traffic, checked beat by beat against a local grading predictor.
// Depends on design/ipod_pkg.sv, design/ipod_if.sv and the block itself.
module tb_top;

    localparam int HOLD_OFF       = 16;
    localparam int END_WAIT       = 40;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASES         = 7;
    localparam int PHASE_FRAMES   = 75;

    localparam int MOUNT_DEG [ipod_pkg::CHANNELS] = '{-17, -49, -90, -120, 120, 90, 49, 17};
    localparam logic [ipod_pkg::CHANNELS-1:0] CORR_MASK = 8'b1001_1001;

    localparam ipod_pkg::cfg_t DEFAULT_CFG = '{ignore: 1'b0,
                                               trig_high: ipod_pkg::RST_TRIG_HIGH,
                                               trig_low: ipod_pkg::RST_TRIG_LOW,
                                               close_level: ipod_pkg::RST_CLOSE,
                                               valid_limit: ipod_pkg::RST_VALID_LIMIT,
                                               side_corr: 12'sd0};

    typedef logic [ipod_pkg::CHANNELS-1:0][ipod_pkg::SAMPLE_BITS-1:0] frame_t;

    typedef struct {
        logic [1:0]                             level;
        logic signed [ipod_pkg::ANGLE_BITS-1:0] dir;
        logic                                   ahead;
        logic                                   stop;
        logic [ipod_pkg::COUNT_BITS-1:0]        count;
    } obstacle_result_t;

    logic                              clk;
    logic                              rst_n;
    logic                              cfg_we;
    logic [ipod_pkg::CFG_IDX_BITS-1:0] cfg_index;
    logic [ipod_pkg::CFG_BITS-1:0]     cfg_data;

    ipod_frame_if  frame_bus ();
    ipod_result_if result_bus ();

    ir_proximity_obstacle_direction u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .frame     (frame_bus),
        .result    (result_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ipod_pkg::cfg_t                   reg_copy;
    logic [ipod_pkg::SAMPLE_BITS-1:0] filt_level [ipod_pkg::CHANNELS];
    ipod_pkg::grade_t                 chan_grade [ipod_pkg::CHANNELS];
    ipod_pkg::grade_t                 held_level;

    obstacle_result_t pending_results [$];
    obstacle_result_t want;
    int               error_count;
    int               idle_cycles;
    int               gap_mode;
    int               burst_left;
    int               rx_cycle;
    int               rx_mode;

    always #5 clk = ~clk;

    function automatic obstacle_result_t predict_obstacle(input frame_t smp);
        obstacle_result_t r;
        int corr;
        int f;
        int angle_sum;
        int hits;
        angle_sum = 0;
        hits      = 0;
        for (int ch = 0; ch < ipod_pkg::CHANNELS; ch++)
        begin
            if (smp[ch] < reg_copy.valid_limit)
            begin
                corr = CORR_MASK[ch] ? int'($signed(reg_copy.side_corr)) : 0;
                f    = (int'(smp[ch]) + int'(filt_level[ch])) >>> 1;
                filt_level[ch] = f[ipod_pkg::SAMPLE_BITS-1:0];
                if (f > int'(reg_copy.close_level) + corr)
                    chan_grade[ch] = ipod_pkg::GRADE_DANGER;
                else if (f > int'(reg_copy.trig_high) + corr)
                    chan_grade[ch] = ipod_pkg::GRADE_DETECTED;
                else if (f < int'(reg_copy.trig_low) + corr)
                    chan_grade[ch] = ipod_pkg::GRADE_NONE;
            end
        end
        for (int ch = 0; ch < ipod_pkg::CHANNELS; ch++)
        begin
            if (chan_grade[ch] != ipod_pkg::GRADE_NONE)
            begin
                hits++;
                angle_sum += MOUNT_DEG[ch];
                if (chan_grade[ch] > held_level)
                    held_level = chan_grade[ch];
            end
        end
        if (chan_grade[3] != ipod_pkg::GRADE_NONE && chan_grade[4] != ipod_pkg::GRADE_NONE)
        begin
            angle_sum = 180;
            hits      = 1;
        end
        if (hits == 0)
            held_level = ipod_pkg::GRADE_NONE;
        r.level = held_level;
        r.dir   = (hits == 0) ? 9'sd0 : 9'(angle_sum / hits);
        r.ahead = (chan_grade[0] == ipod_pkg::GRADE_NONE) &&
                  (chan_grade[1] == ipod_pkg::GRADE_NONE) &&
                  (chan_grade[6] == ipod_pkg::GRADE_NONE) &&
                  (chan_grade[7] == ipod_pkg::GRADE_NONE);
        r.stop  = (hits > 0) && !reg_copy.ignore;
        r.count = ipod_pkg::COUNT_BITS'(hits);
        return r;
    endfunction

    function automatic frame_t frame_of(input int s0, input int s1, input int s2,
                                        input int s3, input int s4, input int s5,
                                        input int s6, input int s7);
        frame_t f;
        f[0] = 12'(s0);
        f[1] = 12'(s1);
        f[2] = 12'(s2);
        f[3] = 12'(s3);
        f[4] = 12'(s4);
        f[5] = 12'(s5);
        f[6] = 12'(s6);
        f[7] = 12'(s7);
        return f;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("[%0t] mismatch %s: got %0d, want %0d", $realtime, what, got, exp_val);
        error_count++;
    endtask

    task automatic send_frame(input frame_t smp);
        @(negedge clk);
        frame_bus.valid    <= 1'b1;
        frame_bus.sample_0 <= smp[0];
        frame_bus.sample_1 <= smp[1];
        frame_bus.sample_2 <= smp[2];
        frame_bus.sample_3 <= smp[3];
        frame_bus.sample_4 <= smp[4];
        frame_bus.sample_5 <= smp[5];
        frame_bus.sample_6 <= smp[6];
        frame_bus.sample_7 <= smp[7];
        @(posedge clk);
        while (!frame_bus.ready)
            @(posedge clk);
        pending_results.push_back(predict_obstacle(smp));
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0 && gap_mode != 0)
        begin
            @(negedge clk);
            frame_bus.valid <= 1'b0;
            if (gap_mode == 1)
            begin
                repeat ($urandom_range(0, 3)) @(posedge clk);
                burst_left = $urandom_range(1, 12);
            end
            else
            begin
                repeat ($urandom_range(4, 30)) @(posedge clk);
                burst_left = $urandom_range(1, 4);
            end
        end
    endtask

    task automatic wait_all_results();
        @(negedge clk);
        frame_bus.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (HOLD_OFF) @(posedge clk);
    endtask

    task automatic write_reg(input ipod_pkg::cfg_idx_t idx,
                             input logic [ipod_pkg::CFG_BITS-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic set_config(input ipod_pkg::cfg_t c);
        write_reg(ipod_pkg::REG_IGNORE, ipod_pkg::CFG_BITS'(c.ignore));
        write_reg(ipod_pkg::REG_TRIG_HIGH, c.trig_high);
        write_reg(ipod_pkg::REG_TRIG_LOW, c.trig_low);
        write_reg(ipod_pkg::REG_CLOSE, c.close_level);
        write_reg(ipod_pkg::REG_VALID_LIMIT, c.valid_limit);
        write_reg(ipod_pkg::REG_SIDE_CORR, c.side_corr);
        @(negedge clk);
        cfg_we   <= 1'b0;
        reg_copy = c;
    endtask

    task automatic test_default_grading();
        gap_mode   = 1;
        burst_left = 3;
        send_frame(frame_of(0, 0, 0, 0, 0, 0, 0, 0));
        send_frame(frame_of(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095));
        send_frame(frame_of(2999, 2999, 2999, 2999, 2999, 2999, 2999, 2999));
        repeat (4) send_frame(frame_of(0, 0, 0, 0, 0, 0, 0, 0));
        send_frame(frame_of(0, 0, 3000, 0, 0, 0, 0, 0));
        send_frame(frame_of(0, 0, 2000, 0, 0, 1000, 0, 0));
        send_frame(frame_of(0, 1000, 0, 0, 0, 0, 0, 0));
        send_frame(frame_of(0, 0, 0, 2500, 0, 0, 0, 0));
        send_frame(frame_of(0, 0, 0, 0, 2500, 0, 0, 0));
        send_frame(frame_of(1365, 2730, 1365, 2730, 1365, 2730, 1365, 2730));
    endtask

    task automatic test_register_extremes();
        ipod_pkg::cfg_t c;
        gap_mode = 0;
        wait_all_results();
        c = '{ignore: 1'b1, trig_high: 12'd0, trig_low: 12'd0, close_level: 12'd4095,
              valid_limit: 12'd4095, side_corr: 12'sh800};
        set_config(c);
        send_frame(frame_of(4094, 4094, 4094, 4094, 4094, 4094, 4094, 4094));
        send_frame(frame_of(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095));
        send_frame(frame_of(0, 0, 0, 0, 0, 0, 0, 0));
        wait_all_results();
        c = '{ignore: 1'b0, trig_high: 12'd4095, trig_low: 12'd4095, close_level: 12'd4095,
              valid_limit: 12'd0, side_corr: 12'sh7FF};
        set_config(c);
        send_frame(frame_of(0, 0, 0, 0, 0, 0, 0, 0));
        send_frame(frame_of(4095, 0, 4095, 0, 4095, 0, 4095, 0));
        wait_all_results();
        c = '{ignore: 1'b0, trig_high: 12'd500, trig_low: 12'd800, close_level: 12'd300,
              valid_limit: 12'd4095, side_corr: -12'sd1024};
        set_config(c);
        send_frame(frame_of(600, 600, 600, 600, 600, 600, 600, 600));
        send_frame(frame_of(200, 200, 200, 200, 200, 200, 200, 200));
        send_frame(frame_of(1000, 0, 1000, 0, 0, 1000, 0, 1000));
        wait_all_results();
        c = '{ignore: 1'b0, trig_high: 12'd0, trig_low: 12'd4095, close_level: 12'd2047,
              valid_limit: 12'd3000, side_corr: 12'sd1024};
        set_config(c);
        send_frame(frame_of(2999, 2999, 2999, 2999, 2999, 2999, 2999, 2999));
        send_frame(frame_of(0, 4095, 0, 4095, 0, 4095, 0, 4095));
        send_frame(frame_of(0, 0, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_random_frames();
        ipod_pkg::cfg_t c;
        frame_t         smp;
        int             target [ipod_pkg::CHANNELS];
        int             s;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_all_results();
            if (phase == 0)
                c = DEFAULT_CFG;
            else if ($urandom_range(0, 2) != 0)
            begin
                c.ignore      = 1'($urandom_range(0, 1));
                c.trig_low    = 12'($urandom_range(0, 800));
                c.trig_high   = 12'(c.trig_low + $urandom_range(0, 800));
                c.close_level = 12'(c.trig_high + $urandom_range(0, 1500));
                c.valid_limit = 12'($urandom_range(1200, 4095));
                c.side_corr   = 12'(int'($urandom_range(0, 2048)) - 1024);
            end
            else
            begin
                c.ignore      = 1'($urandom_range(0, 1));
                c.trig_high   = 12'($urandom_range(0, 4095));
                c.trig_low    = 12'($urandom_range(0, 4095));
                c.close_level = 12'($urandom_range(0, 4095));
                c.valid_limit = 12'($urandom_range(0, 4095));
                c.side_corr   = 12'($urandom_range(0, 4095));
            end
            set_config(c);
            gap_mode   = phase % 3;
            burst_left = 1;
            for (int ch = 0; ch < ipod_pkg::CHANNELS; ch++)
                target[ch] = $urandom_range(0, 4095);
            for (int n = 0; n < PHASE_FRAMES; n++)
            begin
                // in phase 3, drain everything mid-phase, state carries on
                if (phase == 3 && n == PHASE_FRAMES / 2)
                    wait_all_results();
                for (int ch = 0; ch < ipod_pkg::CHANNELS; ch++)
                begin
                    if ($urandom_range(0, 7) == 0)
                    begin
                        case ($urandom_range(0, 6))
                            0: target[ch] = $urandom_range(0, reg_copy.trig_low);
                            1: target[ch] = $urandom_range(reg_copy.trig_low, reg_copy.trig_high);
                            2: target[ch] = $urandom_range(reg_copy.trig_high,
                                                           reg_copy.close_level);
                            3: target[ch] = $urandom_range(reg_copy.close_level, 4095);
                            4: target[ch] = int'(reg_copy.valid_limit) +
                                            int'($urandom_range(0, 3)) - 2;
                            5: target[ch] = $urandom_range(0, 1) ? 4095 : 0;
                            default: target[ch] = $urandom_range(0, 4095);
                        endcase
                    end
                    s = target[ch] + int'($urandom_range(0, 16)) - 8;
                    if ($urandom_range(0, 9) == 0)
                        s = $urandom_range(0, 4095);
                    if (s < 0)
                        s = 0;
                    if (s > 4095)
                        s = 4095;
                    smp[ch] = 12'(s);
                end
                send_frame(smp);
            end
        end
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle % 128 == 0)
                rx_mode <= $urandom_range(0, 3);
            case (rx_mode)
                0:       result_bus.ready <= 1'b1;
                1:       result_bus.ready <= 1'($urandom_range(0, 1));
                2:       result_bus.ready <= (rx_cycle % 5 == 0);
                default: result_bus.ready <= (rx_cycle % 64 > 44);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result beat with nothing pending", 1, 0);
            else
            begin
                want = pending_results.pop_front();
                if (result_bus.obstacle_level !== want.level)
                    report_mismatch("obstacle_level", int'(result_bus.obstacle_level),
                                    int'(want.level));
                if (result_bus.direction_deg !== want.dir)
                    report_mismatch("direction_deg", int'(result_bus.direction_deg),
                                    int'(want.dir));
                if (result_bus.ahead_clear !== want.ahead)
                    report_mismatch("ahead_clear", int'(result_bus.ahead_clear),
                                    int'(want.ahead));
                if (result_bus.stop_drive !== want.stop)
                    report_mismatch("stop_drive", int'(result_bus.stop_drive),
                                    int'(want.stop));
                if (result_bus.triggered_count !== want.count)
                    report_mismatch("triggered_count", int'(result_bus.triggered_count),
                                    int'(want.count));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((frame_bus.valid && frame_bus.ready) || (result_bus.valid && result_bus.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        clk                = 1'b0;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        frame_bus.valid    = 1'b0;
        frame_bus.sample_0 = '0;
        frame_bus.sample_1 = '0;
        frame_bus.sample_2 = '0;
        frame_bus.sample_3 = '0;
        frame_bus.sample_4 = '0;
        frame_bus.sample_5 = '0;
        frame_bus.sample_6 = '0;
        frame_bus.sample_7 = '0;
        result_bus.ready   = 1'b0;
        error_count        = 0;
        idle_cycles        = 0;
        gap_mode           = 0;
        burst_left         = 0;
        rx_cycle           = 0;
        rx_mode            = 0;
        reg_copy           = DEFAULT_CFG;
        held_level         = ipod_pkg::GRADE_NONE;
        for (int ch = 0; ch < ipod_pkg::CHANNELS; ch++)
        begin
            filt_level[ch] = '0;
            chan_grade[ch] = ipod_pkg::GRADE_NONE;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_default_grading();
        test_register_extremes();
        test_random_frames();

        wait_all_results();
        repeat (END_WAIT) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
design/ipod_pkg.sv
design/ipod_if.sv
design/ipod_front.sv
design/ipod_queue.sv
design/ipod_back.sv
design/ir_proximity_obstacle_direction.sv
dv/tb_top.sv
